### rtl/ismc_pkg.sv
// Shared constants, opcode codes and helpers for the IJVM stack-machine core.
package ismc_pkg;

  // Default memory sizes; each must be a power of two.
  localparam int METHOD_BYTES_DEF = 4096;
  localparam int POOL_WORDS_DEF   = 256;
  localparam int STACK_WORDS_DEF  = 1024;

  // Item modes carried in the input tuser field.
  localparam logic [2:0] MODE_LOAD_BYTE = 3'd0;
  localparam logic [2:0] MODE_LOAD_POOL = 3'd1;
  localparam logic [2:0] MODE_PUSH      = 3'd2;
  localparam logic [2:0] MODE_INVOKE    = 3'd3;
  localparam logic [2:0] MODE_EXEC      = 3'd4;

  // Standard IJVM opcodes.
  localparam logic [7:0] OP_NOP           = 8'h00;
  localparam logic [7:0] OP_BIPUSH        = 8'h10;
  localparam logic [7:0] OP_LDC_W         = 8'h13;
  localparam logic [7:0] OP_ILOAD         = 8'h15;
  localparam logic [7:0] OP_ISTORE        = 8'h36;
  localparam logic [7:0] OP_POP           = 8'h57;
  localparam logic [7:0] OP_DUP           = 8'h59;
  localparam logic [7:0] OP_SWAP          = 8'h5F;
  localparam logic [7:0] OP_IADD          = 8'h60;
  localparam logic [7:0] OP_ISUB          = 8'h64;
  localparam logic [7:0] OP_IAND          = 8'h7E;
  localparam logic [7:0] OP_IINC          = 8'h84;
  localparam logic [7:0] OP_IFEQ          = 8'h99;
  localparam logic [7:0] OP_IFLT          = 8'h9B;
  localparam logic [7:0] OP_IF_ICMPEQ     = 8'h9F;
  localparam logic [7:0] OP_GOTO          = 8'hA7;
  localparam logic [7:0] OP_IRETURN       = 8'hAC;
  localparam logic [7:0] OP_IOR           = 8'hB0;
  localparam logic [7:0] OP_INVOKEVIRTUAL = 8'hB6;
  localparam logic [7:0] OP_WIDE          = 8'hC4;

  // Builtin method indexes.
  localparam logic [15:0] BUILTIN_GETCHAR = 16'h8000;
  localparam logic [15:0] BUILTIN_PUTCHAR = 16'h8001;

  // Sign-extend a byte to a word.
  function automatic logic [31:0] sext8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

endpackage

### rtl/ismc_ram.sv
// Single-port-write, single-port-read synchronous RAM with write-to-read forwarding.
module ismc_ram #(
  parameter int W = 32,
  parameter int D = 256,
  localparam int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; a same-cycle write to the read address is forwarded.
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/ijvm_stack_machine_core_unit.sv
// Top level of the IJVM stack-machine core: sequencer around method, pool and stack RAMs.
// Every item passes S_START, S_FIN and S_OUT; executes and invokes pass further states between.
// Items are handled one at a time; the next item can be taken as soon as the result is presented.
// Each result sits in an output register, so the next item is accepted while it waits.
// Reset: synchronous active-low; afterwards the stack RAM is cleared word by word,
// with no item accepted during that sweep; configuration writes are taken whenever out of reset.
module ijvm_stack_machine_core_unit #(
  parameter int METHOD_BYTES = ismc_pkg::METHOD_BYTES_DEF,
  parameter int POOL_WORDS   = ismc_pkg::POOL_WORDS_DEF,
  parameter int STACK_WORDS  = ismc_pkg::STACK_WORDS_DEF,
  localparam int SA       = $clog2(STACK_WORDS),
  localparam int OUT_BITS = 2 * SA + 59,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // address[11:0], data[43:12], in_char[51:44], in_eof[52], zero fill
  input  logic [55:0]      in_tdata,
  // mode[2:0]
  input  logic [2:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // pc_now, sp_now, lv_now, top_word, running, out_valid, out_char, in_taken, zero fill
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data
);
  import ismc_pkg::*;

  localparam int MA = $clog2(METHOD_BYTES);
  localparam int PA = $clog2(POOL_WORDS);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_START, S_OP, S_F1, S_F2, S_EXEC, S_E2, S_E3, S_E4, S_E5,
    S_INV, S_PUT, S_I1, S_I2, S_I3, S_I4, S_I5, S_I6, S_I7, S_FIN, S_OUT
  } state_t;

  state_t st_r, st_nxt;
  logic [15:0]      pc_r, pc_nxt, opc_r, opc_nxt, idx_r, idx_nxt, maddr_r, maddr_nxt;
  logic [SA-1:0]    sp_r, sp_nxt, lv_r, lv_nxt, clr_r, clr_nxt;
  logic             wide_r, wide_nxt;
  logic [15:0]      halt_r;
  logic [2:0]       mode_r, mode_nxt;
  logic [11:0]      iaddr_r, iaddr_nxt;
  logic [31:0]      idata_r, idata_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [7:0]       ch_r, ch_nxt, op_r, op_nxt, b1_r, b1_nxt, b2_r, b2_nxt;
  logic [7:0]       n0_r, n0_nxt, n1_r, n1_nxt, n2_r, n2_nxt, gch_r, gch_nxt;
  logic             eof_r, eof_nxt, got_r, got_nxt, took_r, took_nxt;
  logic [1:0]       nb_r, nb_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  // RAM ports.
  logic          m_we, p_we, s_we;
  logic [MA-1:0] m_waddr, m_raddr;
  logic [7:0]    m_wdata, m_rd;
  logic [PA-1:0] p_waddr, p_raddr;
  logic [31:0]   p_wdata, p_rd;
  logic [SA-1:0] s_waddr, s_raddr;
  logic [31:0]   s_wdata, s_rd;

  // Derived values.
  logic [15:0]   v16, iaddr16, nargs, nlocals;
  logic [SA-1:0] sp_inc, sp_dec, lv_v, lv_b1;
  logic [31:0]   alu;
  logic          in_acc;

  ismc_ram #(.W(8), .D(METHOD_BYTES)) u_method (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rd)
  );
  ismc_ram #(.W(32), .D(POOL_WORDS)) u_pool (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rd)
  );
  ismc_ram #(.W(32), .D(STACK_WORDS)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rd)
  );

  // Number of operand bytes that follow an opcode.
  function automatic logic [1:0] operand_bytes(input logic [7:0] op, input logic wide);
    logic [1:0] n;
    case (op)
      OP_BIPUSH:                  n = 2'd1;
      OP_ILOAD, OP_ISTORE:        n = wide ? 2'd2 : 2'd1;
      OP_GOTO, OP_IFEQ, OP_IFLT,
      OP_IF_ICMPEQ, OP_LDC_W,
      OP_INVOKEVIRTUAL, OP_IINC:  n = 2'd2;
      default:                    n = 2'd0;
    endcase
    return n;
  endfunction

  assign in_tready  = (st_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  assign v16     = (nb_r == 2'd2) ? {b1_r, b2_r} : {8'h00, b1_r};
  assign iaddr16 = {4'h0, iaddr_r};
  assign sp_inc  = sp_r + SA'(1);
  assign sp_dec  = sp_r - SA'(1);
  assign lv_v    = lv_r + v16[SA-1:0];
  assign lv_b1   = lv_r + SA'(b1_r);
  assign nargs   = {n0_r, n1_r};
  assign nlocals = {n2_r, m_rd};

  // Two-operand arithmetic: a is the old top, s_rd the word below it.
  always_comb begin
    case (op_r)
      OP_IADD: alu = a_r + s_rd;
      OP_ISUB: alu = s_rd - a_r;
      OP_IAND: alu = a_r & s_rd;
      OP_IOR:  alu = a_r | s_rd;
      default: alu = a_r;
    endcase
  end

  // Sequencer next-state and RAM control.
  always_comb begin
    st_nxt = st_r; pc_nxt = pc_r; opc_nxt = opc_r; idx_nxt = idx_r; maddr_nxt = maddr_r;
    sp_nxt = sp_r; lv_nxt = lv_r; clr_nxt = clr_r; wide_nxt = wide_r;
    mode_nxt = mode_r; iaddr_nxt = iaddr_r; idata_nxt = idata_r; ch_nxt = ch_r;
    eof_nxt = eof_r; op_nxt = op_r; b1_nxt = b1_r; b2_nxt = b2_r; a_nxt = a_r; b_nxt = b_r;
    n0_nxt = n0_r; n1_nxt = n1_r; n2_nxt = n2_r; gch_nxt = gch_r; got_nxt = got_r;
    took_nxt = took_r; nb_nxt = nb_r; out_data_nxt = out_data_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    m_we = 1'b0; m_waddr = iaddr16[MA-1:0]; m_wdata = idata_r[7:0]; m_raddr = pc_r[MA-1:0];
    p_we = 1'b0; p_waddr = iaddr16[PA-1:0]; p_wdata = idata_r;     p_raddr = v16[PA-1:0];
    s_we = 1'b0; s_waddr = sp_inc;          s_wdata = idata_r;     s_raddr = sp_r;

    case (st_r)
      // Zero the stack after reset.
      S_CLR: begin
        s_we = 1'b1; s_waddr = clr_r; s_wdata = '0;
        clr_nxt = clr_r + SA'(1);
        if (clr_r == '1) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt  = in_tuser;
          iaddr_nxt = in_tdata[11:0];
          idata_nxt = in_tdata[43:12];
          ch_nxt    = in_tdata[51:44];
          eof_nxt   = in_tdata[52];
          got_nxt = 1'b0; gch_nxt = 8'h00; took_nxt = 1'b0;
          st_nxt = S_START;
        end
      end
      // Decode the item's mode.
      S_START: begin
        opc_nxt = pc_r;
        st_nxt  = S_FIN;
        case (mode_r)
          MODE_LOAD_BYTE: m_we = 1'b1;
          MODE_LOAD_POOL: p_we = 1'b1;
          MODE_PUSH: begin
            s_we = 1'b1; sp_nxt = sp_inc;
          end
          MODE_INVOKE: begin
            idx_nxt = iaddr16; st_nxt = S_INV;
          end
          MODE_EXEC: begin
            if (pc_r != halt_r) begin
              pc_nxt = pc_r + 16'd1; st_nxt = S_OP;
            end
          end
          default: st_nxt = S_FIN;
        endcase
      end
      // Opcode arrives; start operand fetch.
      S_OP: begin
        op_nxt   = m_rd;
        wide_nxt = (m_rd == OP_WIDE);
        nb_nxt   = operand_bytes(m_rd, wide_r);
        if (operand_bytes(m_rd, wide_r) != 2'd0) begin
          pc_nxt = pc_r + 16'd1; st_nxt = S_F1;
        end else begin
          st_nxt = S_EXEC;
        end
      end
      S_F1: begin
        b1_nxt = m_rd;
        if (nb_r == 2'd2) begin
          pc_nxt = pc_r + 16'd1; st_nxt = S_F2;
        end else begin
          st_nxt = S_EXEC;
        end
      end
      S_F2: begin
        b2_nxt = m_rd; st_nxt = S_EXEC;
      end
      // First step of each instruction.
      S_EXEC: begin
        st_nxt = S_E2;
        case (op_r)
          OP_BIPUSH: begin
            s_we = 1'b1; s_wdata = sext8(b1_r); sp_nxt = sp_inc; st_nxt = S_FIN;
          end
          OP_GOTO: begin
            pc_nxt = opc_r + v16; st_nxt = S_FIN;
          end
          OP_POP: begin
            sp_nxt = sp_dec; st_nxt = S_FIN;
          end
          OP_IINC:          s_raddr = lv_b1;
          OP_ILOAD:         s_raddr = lv_v;
          OP_IRETURN:       s_raddr = lv_r;
          OP_INVOKEVIRTUAL: begin
            idx_nxt = v16; st_nxt = S_INV;
          end
          OP_DUP, OP_IADD, OP_ISUB, OP_IAND, OP_IOR, OP_IFEQ, OP_IFLT,
          OP_IF_ICMPEQ, OP_ISTORE, OP_SWAP, OP_LDC_W: st_nxt = S_E2;
          default: st_nxt = S_FIN;
        endcase
      end
      S_E2: begin
        st_nxt = S_FIN;
        case (op_r)
          OP_DUP, OP_ILOAD: begin
            s_we = 1'b1; s_wdata = s_rd; sp_nxt = sp_inc;
          end
          OP_LDC_W: begin
            s_we = 1'b1; s_wdata = p_rd; sp_nxt = sp_inc;
          end
          OP_IADD, OP_ISUB, OP_IAND, OP_IOR, OP_IF_ICMPEQ, OP_SWAP: begin
            a_nxt = s_rd; s_raddr = sp_dec; st_nxt = S_E3;
          end
          OP_IFEQ: begin
            sp_nxt = sp_dec;
            if (s_rd == 32'd0) pc_nxt = opc_r + v16;
          end
          OP_IFLT: begin
            sp_nxt = sp_dec;
            if (s_rd[31]) pc_nxt = opc_r + v16;
          end
          OP_IINC: begin
            s_we = 1'b1; s_waddr = lv_b1; s_wdata = s_rd + sext8(b2_r);
          end
          OP_ISTORE: begin
            s_we = 1'b1; s_waddr = lv_v; s_wdata = s_rd; sp_nxt = sp_dec;
          end
          OP_IRETURN: begin
            a_nxt = s_rd; st_nxt = S_E3;
          end
          default: st_nxt = S_FIN;
        endcase
      end
      S_E3: begin
        st_nxt = S_FIN;
        case (op_r)
          OP_IADD, OP_ISUB, OP_IAND, OP_IOR: begin
            s_we = 1'b1; s_waddr = sp_dec; s_wdata = alu; sp_nxt = sp_dec;
          end
          OP_IF_ICMPEQ: begin
            sp_nxt = sp_r - SA'(2);
            if (a_r == s_rd) pc_nxt = opc_r + v16;
          end
          OP_SWAP: begin
            s_we = 1'b1; s_waddr = sp_r; s_wdata = s_rd; st_nxt = S_E4;
          end
          OP_IRETURN: begin
            // Top word moves into the link slot; then read the saved pc.
            s_we = 1'b1; s_waddr = lv_r; s_wdata = s_rd; sp_nxt = lv_r;
            s_raddr = a_r[SA-1:0]; st_nxt = S_E4;
          end
          default: st_nxt = S_FIN;
        endcase
      end
      S_E4: begin
        st_nxt = S_FIN;
        case (op_r)
          OP_SWAP: begin
            s_we = 1'b1; s_waddr = sp_dec; s_wdata = a_r;
          end
          OP_IRETURN: begin
            pc_nxt = s_rd[15:0]; s_raddr = a_r[SA-1:0] + SA'(1); st_nxt = S_E5;
          end
          default: st_nxt = S_FIN;
        endcase
      end
      S_E5: begin
        lv_nxt = s_rd[SA-1:0]; st_nxt = S_FIN;
      end
      // Method call: builtin or pool lookup.
      S_INV: begin
        st_nxt = S_FIN;
        if (idx_r[15]) begin
          if (idx_r == BUILTIN_GETCHAR) begin
            s_we = 1'b1; s_waddr = sp_r;
            s_wdata = eof_r ? 32'hFFFF_FFFF : {24'h0, ch_r};
            took_nxt = 1'b1;
          end else if (idx_r == BUILTIN_PUTCHAR) begin
            st_nxt = S_PUT;
          end
        end else begin
          p_raddr = idx_r[PA-1:0]; st_nxt = S_I1;
        end
      end
      S_PUT: begin
        s_we = 1'b1; s_waddr = sp_dec; s_wdata = {24'h0, s_rd[7:0]}; sp_nxt = sp_dec;
        got_nxt = 1'b1; gch_nxt = s_rd[7:0]; st_nxt = S_FIN;
      end
      S_I1: begin
        maddr_nxt = p_rd[15:0]; m_raddr = p_rd[MA-1:0]; st_nxt = S_I2;
      end
      S_I2: begin
        n0_nxt = m_rd; m_raddr = MA'(maddr_r + 16'd1); st_nxt = S_I3;
      end
      S_I3: begin
        n1_nxt = m_rd; m_raddr = MA'(maddr_r + 16'd2); st_nxt = S_I4;
      end
      S_I4: begin
        n2_nxt = m_rd; m_raddr = MA'(maddr_r + 16'd3); st_nxt = S_I5;
      end
      // Push the return pc and work out the new frame.
      S_I5: begin
        s_we = 1'b1; s_waddr = sp_r + nlocals[SA-1:0] + SA'(1); s_wdata = {16'h0, pc_r};
        sp_nxt = sp_r + nlocals[SA-1:0] + SA'(2);
        a_nxt  = 32'(SA'(sp_r + SA'(1) - nargs[SA-1:0]));
        b_nxt  = 32'(SA'(sp_r + nlocals[SA-1:0] + SA'(1)));
        st_nxt = S_I6;
      end
      S_I6: begin
        s_we = 1'b1; s_waddr = sp_r; s_wdata = 32'(lv_r);
        lv_nxt = a_r[SA-1:0]; st_nxt = S_I7;
      end
      S_I7: begin
        s_we = 1'b1; s_waddr = lv_r; s_wdata = b_r;
        pc_nxt = maddr_r + 16'd4; st_nxt = S_FIN;
      end
      S_FIN: st_nxt = S_OUT;
      // Top word is on the stack read port; hand the result over when the output is free.
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt = OUT_W'({took_r, gch_r, got_r, (pc_r != halt_r), s_rd,
                                 lv_r, sp_r, pc_r});
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; pc_r <= 16'hFFFF; sp_r <= '1; lv_r <= '0; wide_r <= 1'b0;
      clr_r <= '0; halt_r <= 16'hFFFF; out_tvalid_r <= 1'b0;
      got_r <= 1'b0; took_r <= 1'b0; gch_r <= 8'h00;
    end else begin
      st_r <= st_nxt; pc_r <= pc_nxt; sp_r <= sp_nxt; lv_r <= lv_nxt; wide_r <= wide_nxt;
      clr_r <= clr_nxt; out_tvalid_r <= out_tvalid_nxt;
      got_r <= got_nxt; took_r <= took_nxt; gch_r <= gch_nxt;
      if (cfg_valid) halt_r <= cfg_data;
    end
    opc_r <= opc_nxt; idx_r <= idx_nxt; maddr_r <= maddr_nxt; mode_r <= mode_nxt;
    iaddr_r <= iaddr_nxt; idata_r <= idata_nxt; ch_r <= ch_nxt; eof_r <= eof_nxt;
    op_r <= op_nxt; b1_r <= b1_nxt; b2_r <= b2_nxt; a_r <= a_nxt; b_r <= b_nxt;
    n0_r <= n0_nxt; n1_r <= n1_nxt; n2_r <= n2_nxt; nb_r <= nb_nxt;
    out_data_r <= out_data_nxt;
  end

  // No item enters while the stack is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLR) |-> !in_tready)
    else $error("item accepted during stack clear");

  // The stack is never written while the sequencer waits for an item.
  a_no_stack_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> !s_we)
    else $error("stack written while idle");

  // One item never both emits and consumes a character.
  a_io_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(got_r && took_r))
    else $error("putchar and getchar in one item");

  // A waiting result is not overwritten by a finishing item.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |=> (out_tvalid_r && $stable(out_data_r)))
    else $error("pending result lost");

endmodule

### sim/tb.sv
// Self-checking testbench for the IJVM stack-machine core: directed table, then random programs.
`timescale 1ns / 1ps

module tb;
  import ismc_pkg::*;

  // Result item as packed on out_tdata, lowest field in the lowest bits.
  typedef struct packed {
    logic        taken;
    logic [7:0]  oc;
    logic        ov;
    logic        run;
    logic [31:0] top;
    logic [9:0]  lv;
    logic [9:0]  sp;
    logic [15:0] pc;
  } status_t;

  // Kinds of memory holes that must be written before the machine reads them.
  typedef enum int {FILL_OP, FILL_ARG, FILL_INV_HI, FILL_INV_LO, FILL_POOL, FILL_HDR} fill_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  ijvm_stack_machine_core_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Machine state kept by the predictor.
  logic [7:0]  code_mem [4096];
  bit          code_set [4096];
  logic [31:0] pool_mem [256];
  bit          pool_set [256];
  logic [31:0] stack_mem [1024];
  logic [15:0] m_pc;
  logic [9:0]  m_sp;
  logic [9:0]  m_lv;
  logic        m_wide;
  logic [15:0] m_halt;
  logic        putc_flag;
  logic [7:0]  putc_char;
  logic        getc_flag;

  status_t pending_status [$];
  int      n_items;
  int      n_results;
  int      n_errors;
  int      n_putc;
  int      n_getc;
  int      n_run;
  bit      quiet;
  bit      held;

  logic [7:0] opcodes [20] = '{OP_NOP, OP_BIPUSH, OP_LDC_W, OP_ILOAD, OP_ISTORE, OP_POP,
    OP_DUP, OP_SWAP, OP_IADD, OP_ISUB, OP_IAND, OP_IINC, OP_IFEQ, OP_IFLT, OP_IF_ICMPEQ,
    OP_GOTO, OP_IRETURN, OP_IOR, OP_INVOKEVIRTUAL, OP_WIDE};

  // Clock generation.
  always #5 clk = ~clk;

  // Stack helpers of the predictor.
  function automatic void push_word(input logic [31:0] w);
    m_sp = m_sp + 10'd1;
    stack_mem[m_sp] = w;
  endfunction

  function automatic logic [31:0] pop_word();
    logic [31:0] w;
    w = stack_mem[m_sp];
    m_sp = m_sp - 10'd1;
    return w;
  endfunction

  function automatic logic [7:0] fetch8();
    logic [7:0] b;
    b = code_mem[m_pc[11:0]];
    m_pc = m_pc + 16'd1;
    return b;
  endfunction

  function automatic logic [15:0] fetch16();
    logic [7:0] hi;
    logic [7:0] lo;
    hi = fetch8();
    lo = fetch8();
    return {hi, lo};
  endfunction

  // Method call: builtins at the top of the index range, else a frame is built.
  function automatic void call_method(input logic [15:0] idx, input logic [7:0] ch,
                                      input logic eof);
    logic [31:0] a;
    logic [31:0] base;
    logic [11:0] h;
    logic [15:0] nargs;
    logic [15:0] nloc;
    if (idx >= BUILTIN_GETCHAR) begin
      if (idx == BUILTIN_GETCHAR) begin
        void'(pop_word());
        push_word(eof ? 32'hFFFF_FFFF : {24'h0, ch});
        getc_flag = 1'b1;
      end else if (idx == BUILTIN_PUTCHAR) begin
        a = pop_word();
        void'(pop_word());
        push_word({24'h0, a[7:0]});
        putc_flag = 1'b1;
        putc_char = a[7:0];
      end
    end else begin
      base = pool_mem[idx[7:0]];
      h = base[11:0];
      nargs = {code_mem[h], code_mem[h + 12'd1]};
      nloc = {code_mem[h + 12'd2], code_mem[h + 12'd3]};
      m_sp = m_sp + nloc[9:0];
      push_word({16'h0, m_pc});
      push_word({22'h0, m_lv});
      m_lv = m_sp - nargs[9:0] - nloc[9:0] - 10'd1;
      stack_mem[m_lv] = {22'h0, m_sp - 10'd1};
      m_pc = base[15:0] + 16'd4;
    end
  endfunction

  function automatic void return_method();
    logic [31:0] link;
    link = stack_mem[m_lv];
    stack_mem[m_lv] = stack_mem[m_sp];
    m_sp = m_lv;
    m_pc = stack_mem[link[9:0]][15:0];
    m_lv = stack_mem[link[9:0] + 10'd1][9:0];
  endfunction

  // One instruction at the program counter.
  function automatic void run_op(input logic [7:0] ch, input logic eof);
    logic [15:0] opc;
    logic [15:0] off;
    logic [7:0]  op;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [9:0]  idx;
    logic [31:0] a;
    logic [31:0] w;
    opc = m_pc;
    op = fetch8();
    case (op)
      OP_BIPUSH: begin
        b = fetch8();
        push_word({{24{b[7]}}, b});
      end
      OP_DUP: push_word(stack_mem[m_sp]);
      OP_GOTO: begin
        off = fetch16();
        m_pc = opc + off;
      end
      OP_IADD: begin
        a = pop_word(); w = pop_word(); push_word(a + w);
      end
      OP_IAND: begin
        a = pop_word(); w = pop_word(); push_word(a & w);
      end
      OP_IOR: begin
        a = pop_word(); w = pop_word(); push_word(a | w);
      end
      OP_ISUB: begin
        a = pop_word(); w = pop_word(); push_word(w - a);
      end
      OP_IFEQ: begin
        off = fetch16(); a = pop_word();
        if (a == 32'h0) m_pc = opc + off;
      end
      OP_IFLT: begin
        off = fetch16(); a = pop_word();
        if (a[31]) m_pc = opc + off;
      end
      OP_IF_ICMPEQ: begin
        off = fetch16(); a = pop_word(); w = pop_word();
        if (a == w) m_pc = opc + off;
      end
      OP_IINC: begin
        b = fetch8();
        c = fetch8();
        idx = m_lv + {2'b0, b};
        stack_mem[idx] = stack_mem[idx] + {{24{c[7]}}, c};
      end
      OP_ILOAD: begin
        off = m_wide ? fetch16() : {8'h0, fetch8()};
        idx = m_lv + off[9:0];
        push_word(stack_mem[idx]);
      end
      OP_ISTORE: begin
        off = m_wide ? fetch16() : {8'h0, fetch8()};
        idx = m_lv + off[9:0];
        a = pop_word();
        stack_mem[idx] = a;
      end
      OP_INVOKEVIRTUAL: begin
        off = fetch16();
        call_method(off, ch, eof);
      end
      OP_IRETURN: return_method();
      OP_LDC_W: begin
        off = fetch16();
        push_word(pool_mem[off[7:0]]);
      end
      OP_POP: void'(pop_word());
      OP_SWAP: begin
        idx = m_sp - 10'd1;
        a = stack_mem[m_sp];
        stack_mem[m_sp] = stack_mem[idx];
        stack_mem[idx] = a;
      end
      default: ;
    endcase
    m_wide = (op == OP_WIDE);
  endfunction

  // Advance the predictor by one input item and return the status it produces.
  function automatic status_t machine_step(input logic [2:0] mode, input logic [11:0] addr,
      input logic [31:0] data, input logic [7:0] ch, input logic eof);
    status_t s;
    putc_flag = 1'b0;
    putc_char = 8'h0;
    getc_flag = 1'b0;
    case (mode)
      MODE_LOAD_BYTE: begin
        code_mem[addr] = data[7:0];
        code_set[addr] = 1'b1;
      end
      MODE_LOAD_POOL: begin
        pool_mem[addr[7:0]] = data;
        pool_set[addr[7:0]] = 1'b1;
      end
      MODE_PUSH:   push_word(data);
      MODE_INVOKE: call_method({4'h0, addr}, ch, eof);
      MODE_EXEC:   if (m_pc != m_halt) run_op(ch, eof);
      default: ;
    endcase
    s.pc = m_pc;
    s.sp = m_sp;
    s.lv = m_lv;
    s.top = stack_mem[m_sp];
    s.run = (m_pc != m_halt);
    s.ov = putc_flag;
    s.oc = putc_char;
    s.taken = getc_flag;
    return s;
  endfunction

  // Find an unwritten pool word or method header that an invoke would read.
  function automatic bit invoke_hole(input logic [15:0] idx, output fill_t kind,
                                     output logic [11:0] where);
    logic [11:0] h;
    if (idx >= BUILTIN_GETCHAR) return 1'b0;
    if (!pool_set[idx[7:0]]) begin
      kind = FILL_POOL;
      where = {4'h0, idx[7:0]};
      return 1'b1;
    end
    h = pool_mem[idx[7:0]][11:0];
    for (int i = 0; i < 4; i++) begin
      if (!code_set[h + 12'(i)]) begin
        kind = FILL_HDR;
        where = h + 12'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Find an unwritten location that the next instruction would read.
  function automatic bit exec_hole(output fill_t kind, output logic [11:0] where,
                                   output logic [7:0] hint);
    logic [7:0]  op;
    logic [15:0] q;
    logic [15:0] v;
    int          n;
    hint = 8'h0;
    if (!code_set[m_pc[11:0]]) begin
      kind = FILL_OP;
      where = m_pc[11:0];
      return 1'b1;
    end
    op = code_mem[m_pc[11:0]];
    case (op)
      OP_BIPUSH: n = 1;
      OP_GOTO, OP_IFEQ, OP_IFLT, OP_IF_ICMPEQ, OP_LDC_W, OP_INVOKEVIRTUAL, OP_IINC: n = 2;
      OP_ILOAD, OP_ISTORE: n = m_wide ? 2 : 1;
      default: n = 0;
    endcase
    for (int i = 1; i <= n; i++) begin
      q = m_pc + 16'(i);
      if (!code_set[q[11:0]]) begin
        kind = (op != OP_INVOKEVIRTUAL) ? FILL_ARG : (i == 1) ? FILL_INV_HI : FILL_INV_LO;
        where = q[11:0];
        hint = code_mem[m_pc[11:0] + 12'd1];
        return 1'b1;
      end
    end
    q = m_pc + 16'd1;
    v = {code_mem[q[11:0]], code_mem[q[11:0] + 12'd1]};
    if (op == OP_LDC_W && !pool_set[v[7:0]]) begin
      kind = FILL_POOL;
      where = {4'h0, v[7:0]};
      return 1'b1;
    end
    if (op == OP_INVOKEVIRTUAL) return invoke_hole(v, kind, where);
    return 1'b0;
  endfunction

  // Offer one item, wait for it to be taken, and record what it must produce.
  task automatic send_item(input logic [2:0] mode, input logic [11:0] addr,
      input logic [31:0] data, input bit typed, input status_t want);
    int      gap;
    logic [7:0] ch;
    logic    eof;
    status_t s;
    gap = quiet ? 0 : $urandom_range(0, 10);
    ch = 8'($urandom_range(0, 255));
    eof = 1'($urandom_range(0, 1));
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser = mode;
    in_tdata = {3'b0, eof, ch, data, addr};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    s = machine_step(mode, addr, data, ch, eof);
    pending_status.push_back(typed ? want : s);
    n_items++;
    if (s.run) n_run++;
  endtask

  task automatic send_plain(input logic [2:0] mode, input logic [11:0] addr,
                            input logic [31:0] data);
    send_item(mode, addr, data, 1'b0, '0);
  endtask

  // Write a memory hole with content that keeps programs meaningful.
  task automatic fill_hole(input fill_t kind, input logic [11:0] where, input logic [7:0] hint);
    logic [31:0] v;
    v = $urandom;
    case (kind)
      FILL_OP:     if ($urandom_range(0, 99) < 85) v[7:0] = opcodes[$urandom_range(0, 19)];
      FILL_ARG:    if ($urandom_range(0, 1) == 0) v[7:0] = 8'($urandom_range(0, 8));
      FILL_INV_HI: if ($urandom_range(0, 1) == 0) v[7:0] = 8'h80;
      FILL_INV_LO: if (hint == 8'h80) v[7:0] = 8'($urandom_range(0, 3));
      FILL_HDR:    if ($urandom_range(0, 3) != 0) v[7:0] = 8'($urandom_range(0, 3));
      default: ;
    endcase
    if (kind == FILL_POOL) begin
      if ($urandom_range(0, 3) != 0) v = {20'h0, v[11:0]};
      send_plain(MODE_LOAD_POOL, {4'($urandom), where[7:0]}, v);
    end else begin
      send_plain(MODE_LOAD_BYTE, where, v);
    end
  endtask

  // Random programs: mostly execution, with pushes, calls and noise mixed in.
  task automatic random_phase(input int count);
    int          r;
    fill_t       kind;
    logic [11:0] where;
    logic [7:0]  hint;
    logic [11:0] idx;
    int          stop;
    stop = n_items + count;
    while (n_items < stop) begin
      r = $urandom_range(0, 99);
      if (r < 70 && m_pc == m_halt && $urandom_range(0, 2) == 0) r = 80;
      if (r < 70) begin
        while (m_pc != m_halt && exec_hole(kind, where, hint)) fill_hole(kind, where, hint);
        send_plain(MODE_EXEC, 12'($urandom), $urandom);
      end else if (r < 77) begin
        send_plain(MODE_PUSH, 12'($urandom), $urandom);
      end else if (r < 85) begin
        idx = 12'($urandom);
        while (invoke_hole({4'h0, idx}, kind, where)) fill_hole(kind, where, 8'h0);
        send_plain(MODE_INVOKE, idx, $urandom);
      end else if (r < 91) begin
        fill_hole(FILL_OP, 12'($urandom), 8'h0);
      end else if (r < 95) begin
        fill_hole(FILL_POOL, 12'($urandom_range(0, 255)), 8'h0);
      end else begin
        send_plain(3'($urandom_range(5, 7)), 12'($urandom), $urandom);
      end
    end
  endtask

  // Wait until every result is back, then let the block settle before a register write.
  task automatic write_halt(input logic [15:0] value);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    m_halt = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic status_t idle_status(input logic [9:0] sp, input logic [31:0] top);
    status_t s;
    s = '0;
    s.pc = 16'hFFFF;
    s.sp = sp;
    s.top = top;
    return s;
  endfunction

  // Stimulus and end of run.
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = MODE_LOAD_BYTE;
    cfg_valid = 1'b0;
    cfg_data = '0;
    quiet = 1'b0;
    n_items = 0;
    n_run = 0;
    for (int i = 0; i < 4096; i++) code_set[i] = 1'b0;
    for (int i = 0; i < 256; i++) pool_set[i] = 1'b0;
    for (int i = 0; i < 1024; i++) stack_mem[i] = 32'h0;
    m_pc = 16'hFFFF;
    m_sp = 10'h3FF;
    m_lv = 10'h0;
    m_wide = 1'b0;
    m_halt = 16'hFFFF;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_halt(16'hFFFF);

    // Directed: idle machine, unused modes, stack extremes.
    send_item(MODE_EXEC, 12'hFFF, 32'hFFFF_FFFF, 1'b1, idle_status(10'h3FF, 32'h0));
    send_item(3'd5, 12'h0, 32'h0, 1'b1, idle_status(10'h3FF, 32'h0));
    send_item(3'd7, 12'hABC, 32'h1234_5678, 1'b1, idle_status(10'h3FF, 32'h0));
    send_item(MODE_PUSH, 12'h0, 32'h7FFF_FFFF, 1'b1, idle_status(10'h000, 32'h7FFF_FFFF));
    send_item(MODE_PUSH, 12'h0, 32'h8000_0000, 1'b1, idle_status(10'h001, 32'h8000_0000));
    // Method at the top of the method area whose code wraps to address zero.
    send_plain(MODE_LOAD_POOL, 12'hFFF, 32'h0000_0FFC);
    send_plain(MODE_LOAD_BYTE, 12'hFFC, 32'h0);
    send_plain(MODE_LOAD_BYTE, 12'hFFD, 32'h1);
    send_plain(MODE_LOAD_BYTE, 12'hFFE, 32'h0);
    send_plain(MODE_LOAD_BYTE, 12'hFFF, 32'hFFFF_FF00);
    send_plain(MODE_LOAD_BYTE, 12'h000, {24'h0, OP_WIDE});
    send_plain(MODE_LOAD_BYTE, 12'h001, {24'h0, OP_ILOAD});
    send_plain(MODE_LOAD_BYTE, 12'h002, 32'h0);
    send_plain(MODE_LOAD_BYTE, 12'h003, 32'h0);
    send_plain(MODE_LOAD_BYTE, 12'h004, {24'h0, OP_INVOKEVIRTUAL});
    send_plain(MODE_LOAD_BYTE, 12'h005, {24'h0, BUILTIN_PUTCHAR[15:8]});
    send_plain(MODE_LOAD_BYTE, 12'h006, {24'h0, BUILTIN_PUTCHAR[7:0]});
    send_plain(MODE_LOAD_BYTE, 12'h007, 32'h0000_00FE);
    send_plain(MODE_LOAD_BYTE, 12'h008, {24'h0, OP_IRETURN});
    send_plain(MODE_INVOKE, 12'hFFF, 32'h0);
    repeat (5) send_plain(MODE_EXEC, 12'h0, 32'h0);

    // Random phases under several halt settings, one of them without idling.
    write_halt(16'h0000);
    random_phase(300);
    write_halt(16'($urandom));
    quiet = 1'b1;
    random_phase(300);
    quiet = 1'b0;
    write_halt(16'hFFFF);
    random_phase(300);
    write_halt(16'h0010);
    random_phase(300);

    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Ran %0d items (%0d while running), %0d results checked.",
             n_items, n_run, n_results);
    $display("Builtins seen: %0d putchar, %0d getchar; %0d mismatches.",
             n_putc, n_getc, n_errors);
    if (n_errors == 0 && pending_status.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, and the comparison.
  initial begin
    status_t got;
    status_t want;
    int      stall;
    out_tready = 1'b0;
    n_results = 0;
    n_errors = 0;
    n_putc = 0;
    n_getc = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      stall = quiet ? 0 : $urandom_range(0, 10);
      if (n_results == 400 && !held) begin
        held = 1'b1;
        stall = 300;
      end
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = out_tdata[78:0];
      n_results++;
      if (pending_status.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("Unexpected result item: %p", got);
      end else begin
        want = pending_status.pop_front();
        if (want.ov) n_putc++;
        if (want.taken) n_getc++;
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("Mismatch at result %0d:", n_results);
            $display("  expected pc=%h sp=%h lv=%h top=%h run=%b out=%b/%h in=%b",
                     want.pc, want.sp, want.lv, want.top, want.run, want.ov, want.oc,
                     want.taken);
            $display("  actual   pc=%h sp=%h lv=%h top=%h run=%b out=%b/%h in=%b",
                     got.pc, got.sp, got.lv, got.top, got.run, got.ov, got.oc, got.taken);
          end
        end
      end
    end
  end

  // Run limit.
  initial begin
    #8_000_000;
    $display("Timeout with %0d results still outstanding.", pending_status.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
